/* rtl/dac_pkg.sv */
package dac_pkg;

  // Width of the elapsed-time counter; it saturates at all ones.
  localparam int unsigned TimerBits = 16;
  // Width used to compare the timer with a 16-bit limit.
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CmpW      = (TimerBits > CfgW) ? TimerBits : CfgW;

  // Field widths.
  localparam int unsigned OpW     = 4;
  localparam int unsigned IdW     = 8;
  localparam int unsigned PoseW   = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ScreenW = 4;
  localparam int unsigned ArgW    = 8;
  localparam int unsigned SoundW  = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Hold-second counters.
  localparam int unsigned MsW          = 10;
  localparam int unsigned SecW         = 7;
  localparam logic [MsW-1:0] MsPerSecond = MsW'(1000);
  localparam logic [SecW-1:0] SecMax     = '1;

  // Operation codes of the input item.
  localparam logic [OpW-1:0] OpTick       = 4'd0;
  localparam logic [OpW-1:0] OpExit       = 4'd1;
  localparam logic [OpW-1:0] OpEnroll     = 4'd2;
  localparam logic [OpW-1:0] OpDelPress   = 4'd3;
  localparam logic [OpW-1:0] OpDelRelease = 4'd4;
  localparam logic [OpW-1:0] OpOpen       = 4'd5;
  localparam logic [OpW-1:0] OpDenied     = 4'd6;
  localparam logic [OpW-1:0] OpEnrolled   = 4'd7;
  localparam logic [OpW-1:0] OpDeleted    = 4'd8;
  localparam logic [OpW-1:0] OpReady      = 4'd9;
  localparam logic [OpW-1:0] OpPose       = 4'd10;

  // Modes.
  localparam logic [ModeW-1:0] ModeIdle      = 3'd0;
  localparam logic [ModeW-1:0] ModeUnlocked  = 3'd1;
  localparam logic [ModeW-1:0] ModeEnrolling = 3'd2;
  localparam logic [ModeW-1:0] ModeHold      = 3'd3;
  localparam logic [ModeW-1:0] ModeDeleting  = 3'd4;
  localparam logic [ModeW-1:0] ModeDenied    = 3'd5;

  // Screens.
  localparam logic [ScreenW-1:0] ScrNone       = 4'd0;
  localparam logic [ScreenW-1:0] ScrReady      = 4'd1;
  localparam logic [ScreenW-1:0] ScrOpenFace   = 4'd2;
  localparam logic [ScreenW-1:0] ScrOpenExit   = 4'd3;
  localparam logic [ScreenW-1:0] ScrDenied     = 4'd4;
  localparam logic [ScreenW-1:0] ScrEnrolling  = 4'd5;
  localparam logic [ScreenW-1:0] ScrPose       = 4'd6;
  localparam logic [ScreenW-1:0] ScrEnrolled   = 4'd7;
  localparam logic [ScreenW-1:0] ScrDeleted    = 4'd8;
  localparam logic [ScreenW-1:0] ScrHold       = 4'd9;
  localparam logic [ScreenW-1:0] ScrDeleting   = 4'd10;

  // Sounds.
  localparam logic [SoundW-1:0] SndNone     = 4'd0;
  localparam logic [SoundW-1:0] SndOpen     = 4'd1;
  localparam logic [SoundW-1:0] SndDenied   = 4'd2;
  localparam logic [SoundW-1:0] SndLook     = 4'd3;
  localparam logic [SoundW-1:0] SndEnrolled = 4'd4;
  localparam logic [SoundW-1:0] SndDeleted  = 4'd5;

  // Link commands.
  localparam logic [CmdW-1:0] CmdNone   = 2'd0;
  localparam logic [CmdW-1:0] CmdEnroll = 2'd1;
  localparam logic [CmdW-1:0] CmdDelAll = 2'd2;
  localparam logic [CmdW-1:0] CmdCancel = 2'd3;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegRelayOpen  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDelHold    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDenied     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEnrollTo   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDelGuard   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDebounce   = 3'd5;

  // Reset values of the registers.
  localparam logic [CfgW-1:0] RelayOpenRst = 16'd3000;
  localparam logic [CfgW-1:0] DelHoldRst   = 16'd3000;
  localparam logic [CfgW-1:0] DeniedRst    = 16'd2500;
  localparam logic [CfgW-1:0] EnrollToRst  = 16'd15000;
  localparam logic [CfgW-1:0] DelGuardRst  = 16'd10000;
  localparam logic [CfgW-1:0] DebounceRst  = 16'd200;

  // Button slots of the debouncers.
  localparam int unsigned NumButtons = 3;
  localparam int unsigned BtnExit    = 0;
  localparam int unsigned BtnEnroll  = 1;
  localparam int unsigned BtnDelete  = 2;

  typedef struct packed {
    logic [CfgW-1:0] open_time;
    logic [CfgW-1:0] del_hold;
    logic [CfgW-1:0] denied;
    logic [CfgW-1:0] enroll_to;
    logic [CfgW-1:0] del_guard;
  } limits_t;

  // Working state and raised outputs while one request is handled.
  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic                 relay;
    logic [TimerBits-1:0] elapsed;
    logic [ScreenW-1:0]   screen;
    logic [ArgW-1:0]      arg;
    logic [SoundW-1:0]    sound;
    logic [CmdW-1:0]      cmd;
    logic                 hold_ended;
  } ctx_t;

endpackage

/* rtl/door_access_controller.sv */
// Door access controller. Every request on the slave stream (a 1 ms tick, a
// button press or release, or a recognizer message) yields exactly one result
// on the master stream with the mode, the relay and the screen, sound and
// link command raised by it. One request is taken per clock cycle: the whole
// update is one pass of logic between the state registers and the result
// register, and a new request is taken while the previous result waits as
// long as the master side takes it in the same cycle. Configuration writes
// are taken at any time (ready is always high) and are meant to be made
// while the block is idle; a write to an index above 5 is ignored.
module door_access_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream, tdata from bit 0: op[3:0], face_id[11:4], pose_step[14:12].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dac_pkg::InDataW-1:0]   s_axis_tdata,
  // Master stream, tdata from bit 0: door_relay[0], mode[3:1], screen[7:4],
  // screen_arg[15:8], sound[19:16], command[21:20].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dac_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dac_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dac_pkg::CfgW-1:0]      cfg_data_i
);
  import dac_pkg::*;

  localparam logic [TimerBits-1:0] TimerMax = '1;

  // Configuration registers.
  limits_t         lim_q;
  logic [CfgW-1:0] debounce_q;

  // Block state.
  logic [ModeW-1:0]     mode_q, mode_d;
  logic                 relay_q, relay_d;
  logic [TimerBits-1:0] elapsed_q, elapsed_d;
  logic [MsW-1:0]       ms_q, ms_d;
  logic [SecW-1:0]      sec_q, sec_d;
  logic [CfgW-1:0]      deb_q [NumButtons];
  logic [CfgW-1:0]      deb_d [NumButtons];
  logic                 pend_exit_q, pend_exit_d;
  logic                 pend_enroll_q, pend_enroll_d;

  // Result register.
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic in_accept;
  logic [OpW-1:0]   op;
  logic [IdW-1:0]   face_id;
  logic [PoseW-1:0] pose_step;
  ctx_t             ctx;

  assign op        = s_axis_tdata[OpW-1:0];
  assign face_id   = s_axis_tdata[OpW+IdW-1:OpW];
  assign pose_step = s_axis_tdata[OpW+IdW+PoseW-1:OpW+IdW];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  function automatic logic reached(logic [TimerBits-1:0] el, logic [CfgW-1:0] lim);
    reached = CmpW'(el) >= CmpW'(lim);
  endfunction

  function automatic ctx_t show(ctx_t c, logic [ScreenW-1:0] scr, logic [ArgW-1:0] arg);
    ctx_t r;
    r        = c;
    r.screen = scr;
    r.arg    = arg;
    return r;
  endfunction

  function automatic ctx_t unlock(ctx_t c, logic by_exit, logic [IdW-1:0] id);
    ctx_t r;
    r         = c;
    r.relay   = 1'b1;
    r.mode    = ModeUnlocked;
    r.elapsed = '0;
    r         = by_exit ? show(r, ScrOpenExit, '0) : show(r, ScrOpenFace, id);
    r.sound   = SndOpen;
    return r;
  endfunction

  function automatic ctx_t press_exit(ctx_t c);
    ctx_t r;
    r = c;
    if (c.mode == ModeUnlocked) begin
      r.elapsed = '0;
    end else begin
      r = unlock(c, 1'b1, '0);
    end
    return r;
  endfunction

  function automatic ctx_t press_enroll(ctx_t c);
    ctx_t r;
    r = c;
    if (c.mode == ModeIdle) begin
      r.mode    = ModeEnrolling;
      r.elapsed = '0;
      r.cmd     = CmdEnroll;
      r         = show(r, ScrEnrolling, '0);
      r.sound   = SndLook;
    end
    return r;
  endfunction

  // Timeout checks of the current mode, the end of the hold first.
  function automatic ctx_t settle(ctx_t c, limits_t lim);
    ctx_t r;
    r = c;
    if (r.mode == ModeHold && reached(r.elapsed, lim.del_hold)) begin
      r            = show(r, ScrDeleting, '0);
      r.cmd        = CmdDelAll;
      r.mode       = ModeDeleting;
      r.elapsed    = '0;
      r.hold_ended = 1'b1;
    end
    unique case (r.mode)
      ModeUnlocked: begin
        if (reached(r.elapsed, lim.open_time)) begin
          r.relay = 1'b0;
          r.mode  = ModeIdle;
          r       = show(r, ScrReady, '0);
        end
      end
      ModeDenied: begin
        if (reached(r.elapsed, lim.denied)) begin
          r.mode = ModeIdle;
          r      = show(r, ScrReady, '0);
        end
      end
      ModeEnrolling: begin
        if (reached(r.elapsed, lim.enroll_to)) begin
          r.mode = ModeIdle;
          r.cmd  = CmdCancel;
          r      = show(r, ScrReady, '0);
        end
      end
      ModeDeleting: begin
        if (reached(r.elapsed, lim.del_guard)) begin
          r.mode = ModeIdle;
          r      = show(r, ScrReady, '0);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Next state and result of one request.
  always_comb begin
    logic             holding;
    logic [ArgW-1:0]  res_arg;
    holding        = (mode_q == ModeHold);
    ctx.mode       = mode_q;
    ctx.relay      = relay_q;
    ctx.elapsed    = elapsed_q;
    ctx.screen     = ScrNone;
    ctx.arg        = '0;
    ctx.sound      = SndNone;
    ctx.cmd        = CmdNone;
    ctx.hold_ended = 1'b0;
    ms_d           = ms_q;
    sec_d          = sec_q;
    pend_exit_d    = pend_exit_q;
    pend_enroll_d  = pend_enroll_q;
    for (int b = 0; b < NumButtons; b++) begin
      deb_d[b] = deb_q[b];
    end

    unique case (op)
      OpTick: begin
        for (int b = 0; b < NumButtons; b++) begin
          if (deb_q[b] != '0) deb_d[b] = deb_q[b] - CfgW'(1);
        end
        if (elapsed_q != TimerMax) ctx.elapsed = elapsed_q + TimerBits'(1);
        if (holding) begin
          if (ms_q + MsW'(1) >= MsPerSecond) begin
            ms_d = '0;
            if (sec_q != SecMax) sec_d = sec_q + SecW'(1);
            ctx  = show(ctx, ScrHold, ArgW'(sec_d));
          end else begin
            ms_d = ms_q + MsW'(1);
          end
        end
      end
      OpExit: begin
        if (deb_q[BtnExit] == '0) begin
          deb_d[BtnExit] = debounce_q;
          if (holding) pend_exit_d = 1'b1;
          else ctx = press_exit(ctx);
        end
      end
      OpEnroll: begin
        if (deb_q[BtnEnroll] == '0) begin
          deb_d[BtnEnroll] = debounce_q;
          if (holding) pend_enroll_d = 1'b1;
          else ctx = press_enroll(ctx);
        end
      end
      OpDelPress: begin
        if (deb_q[BtnDelete] == '0) begin
          deb_d[BtnDelete] = debounce_q;
          if (mode_q == ModeIdle) begin
            ctx.mode      = ModeHold;
            ctx.elapsed   = '0;
            ms_d          = '0;
            sec_d         = '0;
            pend_exit_d   = 1'b0;
            pend_enroll_d = 1'b0;
            ctx           = show(ctx, ScrHold, '0);
          end
        end
      end
      OpDelRelease: begin
        if (holding) begin
          ctx.mode       = ModeIdle;
          ctx            = show(ctx, ScrReady, '0);
          ctx.hold_ended = 1'b1;
        end
      end
      default: begin
        // Recognizer messages; all of them are ignored during the hold.
        if (!holding) begin
          priority if (op == OpOpen) begin
            ctx = unlock(ctx, 1'b0, face_id);
          end else if (op == OpDenied) begin
            if (mode_q == ModeIdle) begin
              ctx.mode    = ModeDenied;
              ctx.elapsed = '0;
              ctx         = show(ctx, ScrDenied, '0);
              ctx.sound   = SndDenied;
            end
          end else if (op == OpEnrolled) begin
            ctx.mode    = ModeIdle;
            ctx.elapsed = '0;
            ctx         = show(ctx, ScrEnrolled, face_id);
            ctx.sound   = SndEnrolled;
          end else if (op == OpDeleted) begin
            ctx.mode    = ModeIdle;
            ctx.elapsed = '0;
            ctx         = show(ctx, ScrDeleted, '0);
            ctx.sound   = SndDeleted;
          end else if (op == OpReady) begin
            ctx.mode = ModeIdle;
            ctx      = show(ctx, ScrReady, '0);
          end else if (op == OpPose) begin
            if (pose_step >= PoseW'(1) && pose_step <= PoseW'(5)) begin
              ctx.elapsed = '0;
              ctx         = show(ctx, ScrPose, ArgW'(pose_step));
              ctx.sound   = SndDeleted + SoundW'(pose_step);
            end
          end else begin
          end
        end
      end
    endcase

    ctx = settle(ctx, lim_q);

    // Presses latched during the hold are applied once it ends, exit first.
    if (ctx.hold_ended) begin
      if (pend_exit_d) ctx = press_exit(ctx);
      if (pend_enroll_d) ctx = press_enroll(ctx);
      pend_exit_d   = 1'b0;
      pend_enroll_d = 1'b0;
      ctx = settle(ctx, lim_q);
    end

    mode_d    = ctx.mode;
    relay_d   = ctx.relay;
    elapsed_d = ctx.elapsed;
    res_arg   = (ctx.screen == ScrNone) ? '0 : ctx.arg;
    m_data_d  = {2'b00, ctx.cmd, ctx.sound, res_arg, ctx.screen, ctx.mode, ctx.relay};
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.open_time <= RelayOpenRst;
      lim_q.del_hold  <= DelHoldRst;
      lim_q.denied    <= DeniedRst;
      lim_q.enroll_to <= EnrollToRst;
      lim_q.del_guard <= DelGuardRst;
      debounce_q      <= DebounceRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegRelayOpen: lim_q.open_time <= cfg_data_i;
        RegDelHold:   lim_q.del_hold  <= cfg_data_i;
        RegDenied:    lim_q.denied    <= cfg_data_i;
        RegEnrollTo:  lim_q.enroll_to <= cfg_data_i;
        RegDelGuard:  lim_q.del_guard <= cfg_data_i;
        RegDebounce:  debounce_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // State update on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeIdle;
      relay_q       <= 1'b0;
      elapsed_q     <= '0;
      ms_q          <= '0;
      sec_q         <= '0;
      pend_exit_q   <= 1'b0;
      pend_enroll_q <= 1'b0;
      for (int b = 0; b < NumButtons; b++) begin
        deb_q[b] <= '0;
      end
    end else if (in_accept) begin
      mode_q        <= mode_d;
      relay_q       <= relay_d;
      elapsed_q     <= elapsed_d;
      ms_q          <= ms_d;
      sec_q         <= sec_d;
      pend_exit_q   <= pend_exit_d;
      pend_enroll_q <= pend_enroll_d;
      for (int b = 0; b < NumButtons; b++) begin
        deb_q[b] <= deb_d[b];
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dac_pkg::*;

  // Pose steps that carry a pose screen and track.
  localparam logic [PoseW-1:0] PoseFirst = 3'd1;
  localparam logic [PoseW-1:0] PoseLast  = 3'd5;

  // Request as packed on the slave tdata, lowest field last.
  typedef struct packed {
    logic             pad;
    logic [PoseW-1:0] pose;
    logic [IdW-1:0]   id;
    logic [OpW-1:0]   op;
  } request_t;

  // Result as packed on the master tdata, lowest field last.
  typedef struct packed {
    logic [1:0]         pad;
    logic [CmdW-1:0]    cmd;
    logic [SoundW-1:0]  sound;
    logic [ArgW-1:0]    arg;
    logic [ScreenW-1:0] screen;
    logic [ModeW-1:0]   mode;
    logic               relay;
  } panel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  door_access_controller u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Expected panels in request order, and the error tally.
  panel_t panel_due[$];
  int     errors = 0;
  int     results_checked = 0;

  // Idling controls of the sender and the receiver.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold_cycles = 0;

  // Controller state as the predictor sees it.
  logic [ModeW-1:0]     door_mode;
  logic                 relay_live;
  logic [TimerBits-1:0] ms_elapsed;
  logic [MsW-1:0]       ms_into_second;
  logic [SecW-1:0]      held_secs;
  logic [CfgW-1:0]      press_guard [NumButtons];
  logic                 exit_latched;
  logic                 enroll_latched;
  limits_t              lim;
  logic [CfgW-1:0]      debounce_len;

  // Outputs raised while one request is worked out.
  logic [ScreenW-1:0] raised_screen;
  logic [ArgW-1:0]    raised_arg;
  logic [SoundW-1:0]  raised_sound;
  logic [CmdW-1:0]    raised_cmd;
  logic               hold_done;

  function automatic void show_screen(logic [ScreenW-1:0] scr, logic [ArgW-1:0] arg);
    raised_screen = scr;
    raised_arg = arg;
  endfunction

  function automatic void unlock_door(logic by_exit, logic [IdW-1:0] id);
    relay_live = 1'b1;
    door_mode = ModeUnlocked;
    ms_elapsed = '0;
    if (by_exit) begin
      show_screen(ScrOpenExit, '0);
    end else begin
      show_screen(ScrOpenFace, id);
    end
    raised_sound = SndOpen;
  endfunction

  function automatic void apply_exit();
    if (door_mode == ModeUnlocked) begin
      ms_elapsed = '0;
    end else begin
      unlock_door(1'b1, '0);
    end
  endfunction

  function automatic void apply_enroll();
    if (door_mode == ModeIdle) begin
      door_mode = ModeEnrolling;
      ms_elapsed = '0;
      raised_cmd = CmdEnroll;
      show_screen(ScrEnrolling, '0);
      raised_sound = SndLook;
    end
  endfunction

  // A press counts only once its button's debounce count has run out.
  function automatic logic take_press(int unsigned btn);
    if (press_guard[btn] != '0) begin
      return 1'b0;
    end
    press_guard[btn] = debounce_len;
    return 1'b1;
  endfunction

  // Ends the current mode once its limit is reached.
  function automatic void settle_timeouts();
    if (door_mode == ModeHold && ms_elapsed >= lim.del_hold) begin
      show_screen(ScrDeleting, '0);
      raised_cmd = CmdDelAll;
      door_mode = ModeDeleting;
      ms_elapsed = '0;
      hold_done = 1'b1;
    end
    case (door_mode)
      ModeUnlocked: begin
        if (ms_elapsed >= lim.open_time) begin
          relay_live = 1'b0;
          door_mode = ModeIdle;
          show_screen(ScrReady, '0);
        end
      end
      ModeDenied: begin
        if (ms_elapsed >= lim.denied) begin
          door_mode = ModeIdle;
          show_screen(ScrReady, '0);
        end
      end
      ModeEnrolling: begin
        if (ms_elapsed >= lim.enroll_to) begin
          door_mode = ModeIdle;
          raised_cmd = CmdCancel;
          show_screen(ScrReady, '0);
        end
      end
      ModeDeleting: begin
        if (ms_elapsed >= lim.del_guard) begin
          door_mode = ModeIdle;
          show_screen(ScrReady, '0);
        end
      end
      default: ;
    endcase
  endfunction

  // Works out the panel that one request produces and advances the state.
  function automatic panel_t predict_panel(request_t req);
    panel_t due;
    logic   holding;
    holding = (door_mode == ModeHold);
    raised_screen = ScrNone;
    raised_arg = '0;
    raised_sound = SndNone;
    raised_cmd = CmdNone;
    hold_done = 1'b0;

    case (req.op)
      OpTick: begin
        for (int b = 0; b < NumButtons; b++) begin
          if (press_guard[b] != '0) press_guard[b]--;
        end
        if (ms_elapsed != '1) ms_elapsed++;
        if (door_mode == ModeHold) begin
          ms_into_second++;
          if (ms_into_second >= MsPerSecond) begin
            ms_into_second = '0;
            if (held_secs != SecMax) held_secs++;
            show_screen(ScrHold, ArgW'(held_secs));
          end
        end
      end
      OpExit: begin
        if (take_press(BtnExit)) begin
          if (holding) exit_latched = 1'b1;
          else apply_exit();
        end
      end
      OpEnroll: begin
        if (take_press(BtnEnroll)) begin
          if (holding) enroll_latched = 1'b1;
          else apply_enroll();
        end
      end
      OpDelPress: begin
        if (take_press(BtnDelete) && door_mode == ModeIdle) begin
          door_mode = ModeHold;
          ms_elapsed = '0;
          ms_into_second = '0;
          held_secs = '0;
          exit_latched = 1'b0;
          enroll_latched = 1'b0;
          show_screen(ScrHold, '0);
        end
      end
      OpDelRelease: begin
        if (holding) begin
          door_mode = ModeIdle;
          show_screen(ScrReady, '0);
          hold_done = 1'b1;
        end
      end
      OpOpen: begin
        if (!holding) unlock_door(1'b0, req.id);
      end
      OpDenied: begin
        if (!holding && door_mode == ModeIdle) begin
          door_mode = ModeDenied;
          ms_elapsed = '0;
          show_screen(ScrDenied, '0);
          raised_sound = SndDenied;
        end
      end
      OpEnrolled: begin
        if (!holding) begin
          door_mode = ModeIdle;
          ms_elapsed = '0;
          show_screen(ScrEnrolled, req.id);
          raised_sound = SndEnrolled;
        end
      end
      OpDeleted: begin
        if (!holding) begin
          door_mode = ModeIdle;
          ms_elapsed = '0;
          show_screen(ScrDeleted, '0);
          raised_sound = SndDeleted;
        end
      end
      OpReady: begin
        if (!holding) begin
          door_mode = ModeIdle;
          show_screen(ScrReady, '0);
        end
      end
      OpPose: begin
        if (!holding && req.pose >= PoseFirst && req.pose <= PoseLast) begin
          ms_elapsed = '0;
          show_screen(ScrPose, ArgW'(req.pose));
          // The pose tracks follow the deleted track.
          raised_sound = SndDeleted + SoundW'(req.pose);
        end
      end
      default: ;
    endcase

    // Presses latched during a delete hold apply when it ends, exit first.
    settle_timeouts();
    if (hold_done) begin
      if (exit_latched) begin
        exit_latched = 1'b0;
        apply_exit();
      end
      if (enroll_latched) begin
        enroll_latched = 1'b0;
        apply_enroll();
      end
      settle_timeouts();
    end

    due.pad = '0;
    due.cmd = raised_cmd;
    due.sound = raised_sound;
    due.arg = (raised_screen == ScrNone) ? '0 : raised_arg;
    due.screen = raised_screen;
    due.mode = door_mode;
    due.relay = relay_live;
    return due;
  endfunction

  // Random request, biased toward what moves the current mode along.
  function automatic request_t pick_request();
    request_t    req;
    int unsigned roll;
    req.pad = 1'b0;
    req.id = IdW'($urandom);
    req.pose = PoseW'($urandom_range(PoseFirst, PoseLast));
    roll = $urandom_range(99);
    if (roll < 3) begin
      // Operation codes that the block does not use.
      req.op = OpW'($urandom_range(OpPose + 1, (1 << OpW) - 1));
    end else if (roll < 6) begin
      // Pose steps out of range; the top value wraps to zero.
      req.op = OpPose;
      req.pose = PoseW'($urandom_range(PoseLast + 1, PoseLast + 3));
    end else begin
      roll = $urandom_range(99);
      case (door_mode)
        ModeHold: begin
          if (roll < 60) req.op = OpTick;
          else if (roll < 70) req.op = OpDelRelease;
          else if (roll < 78) req.op = OpExit;
          else if (roll < 86) req.op = OpEnroll;
          else req.op = OpW'($urandom_range(OpDelPress, OpPose));
        end
        ModeEnrolling: begin
          if (roll < 50) req.op = OpTick;
          else if (roll < 80) req.op = OpPose;
          else if (roll < 88) req.op = OpEnrolled;
          else req.op = OpW'($urandom_range(OpExit, OpPose));
        end
        default: begin
          if (roll < 55) req.op = OpTick;
          else req.op = OpW'($urandom_range(OpExit, OpPose));
        end
      endcase
    end
    return req;
  endfunction

  task automatic set_idling(int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Sends one request and records the panel it should produce.
  task automatic send_request(logic [OpW-1:0] op, logic [IdW-1:0] id,
                              logic [PoseW-1:0] pose);
    request_t req;
    req = {1'b0, pose, id, op};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    panel_due.push_back(predict_panel(req));
  endtask

  task automatic send_ticks(int count);
    for (int i = 0; i < count; i++) send_request(OpTick, '0, '0);
  endtask

  task automatic send_random(int count);
    request_t req;
    for (int i = 0; i < count; i++) begin
      req = pick_request();
      send_request(req.op, req.id, req.pose);
    end
  endtask

  // Stops sending and waits until every expected panel has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (panel_due.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes all six limits, then random data to the two unused indexes.
  task automatic set_limits(logic [CfgW-1:0] relay_ms, logic [CfgW-1:0] hold_ms,
                            logic [CfgW-1:0] denied_len, logic [CfgW-1:0] enroll_ms,
                            logic [CfgW-1:0] guard_ms, logic [CfgW-1:0] press_gap);
    logic [CfgW-1:0] value [1 << CfgIdxW];
    value = '{relay_ms, hold_ms, denied_len, enroll_ms, guard_ms, press_gap,
              CfgW'($urandom), CfgW'($urandom)};
    for (int i = 0; i < (1 << CfgIdxW); i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i <= value[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (CfgIdxW'(i))
        RegRelayOpen: lim.open_time = value[i];
        RegDelHold:   lim.del_hold = value[i];
        RegDenied:    lim.denied = value[i];
        RegEnrollTo:  lim.enroll_to = value[i];
        RegDelGuard:  lim.del_guard = value[i];
        RegDebounce:  debounce_len = value[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d, %s: expected %0h, got %0h", results_checked, what, want, seen);
      end
    end
  endfunction

  // Receiver: random stalls, long hold-offs on request, and the panel check.
  always @(posedge clk_i) begin : sink_side
    panel_t seen;
    panel_t want;
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (panel_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no request pending: %h", seen);
      end else begin
        want = panel_due.pop_front();
        check_field("door_relay", 8'(want.relay), 8'(seen.relay));
        check_field("mode", 8'(want.mode), 8'(seen.mode));
        check_field("screen", 8'(want.screen), 8'(seen.screen));
        check_field("screen_arg", want.arg, seen.arg);
        check_field("sound", 8'(want.sound), 8'(seen.sound));
        check_field("command", 8'(want.cmd), 8'(seen.cmd));
        check_field("padding", 8'(want.pad), 8'(seen.pad));
      end
      results_checked++;
    end
  end

  // Every operation once, field extremes, a limit of zero, and a delete hold
  // that latches both presses and ends with them applied.
  task automatic test_directed_sequence();
    drain_results();
    set_idling(0, 57);
    set_limits(16'd5, 16'd2, 16'd0, 16'd3, 16'd0, 16'd0);
    send_request(OpTick, '0, '0);
    send_request(OpOpen, 8'hFF, '0);
    send_request(OpExit, '0, '0);
    send_request(OpEnroll, '0, '0);
    send_request(OpDenied, '0, '0);
    send_request(OpReady, '0, '0);
    send_request(OpDenied, '0, '0);
    send_request(OpEnroll, '0, '0);
    send_request(OpPose, 8'hFF, 3'd5);
    send_request(OpPose, '0, 3'd0);
    send_request(OpPose, '0, 3'd7);
    send_ticks(3);
    send_request(OpEnrolled, 8'h00, '0);
    send_request(OpW'((1 << OpW) - 1), 8'hFF, 3'd7);
    send_request(OpW'(OpPose + 1), '0, '0);
    send_request(OpDelRelease, '0, '0);
    send_request(OpDelPress, '0, '0);
    send_request(OpExit, '0, '0);
    send_request(OpEnroll, '0, '0);
    send_request(OpOpen, 8'h5A, '0);
    send_request(OpDelPress, '0, '0);
    send_ticks(2);
    send_request(OpDeleted, '0, '0);
  endtask

  // A long delete hold that passes a whole second and runs to the delete-all
  // command while presses and messages arrive, then a short one that is
  // released early with an enroll press waiting.
  task automatic test_delete_hold_progress();
    drain_results();
    set_idling(35, 35);
    set_limits(16'd25, 16'd1040, 16'd20, 16'd30, 16'd40, 16'd150);
    send_request(OpDelPress, '0, '0);
    for (int i = 0; i < 1060; i++) begin
      case ($urandom_range(49))
        0: send_request(OpExit, '0, '0);
        1: send_request(OpEnroll, '0, '0);
        2: send_request(OpOpen, IdW'($urandom), '0);
        3: send_request(OpDenied, '0, '0);
        default: ;
      endcase
      send_request(OpTick, '0, '0);
    end
    send_request(OpReady, '0, '0);
    send_ticks(200);
    send_request(OpDelPress, '0, '0);
    send_ticks(5);
    send_request(OpEnroll, '0, '0);
    send_ticks(30);
    send_request(OpDelRelease, '0, '0);
    send_ticks(10);
  endtask

  // The receiver holds off while requests keep coming, then the sender
  // waits for every result before going on.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    sink_hold_cycles = 300;
    send_random(80);
    drain_results();
  endtask

  // Random traffic under several limit settings and idling patterns.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(57, 0);
        2: set_idling(0, 57);
        default: set_idling(35, 35);
      endcase
      if (phase == 0) begin
        set_limits('0, '0, '0, '0, '0, '0);
      end else if (phase == 1) begin
        set_limits('1, '1, '1, '1, '1, '1);
      end else begin
        set_limits(CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 40)),
                   CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 40)),
                   CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 12)));
      end
      send_random(30);
    end
  endtask

  initial begin
    door_mode = ModeIdle;
    relay_live = 1'b0;
    ms_elapsed = '0;
    ms_into_second = '0;
    held_secs = '0;
    for (int b = 0; b < NumButtons; b++) press_guard[b] = '0;
    exit_latched = 1'b0;
    enroll_latched = 1'b0;
    lim = {RelayOpenRst, DelHoldRst, DeniedRst, EnrollToRst, DelGuardRst};
    debounce_len = DebounceRst;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_sequence();
    test_delete_hold_progress();
    test_output_backpressure();
    test_random_traffic();
    drain_results();

    if (errors == 0 && panel_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
